// ===== hw/rtl/osq_pkg.sv =====
// Shared types, codes and the segment table of the odometry segment sequencer.
// Used by osq_cfg_regs, osq_seg_eval and odometry_segment_sequencer.
`default_nettype none

package osq_pkg;

  localparam int IDX_W = 4;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_ACK    = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_HALT  = 2'd1;
  localparam logic [1:0] CMD_DRIVE = 2'd2;

  localparam logic [1:0] REG_LIN_SPEED    = 2'd0;
  localparam logic [1:0] REG_ROTATE_SPEED = 2'd1;
  localparam logic [1:0] REG_POS_TOL      = 2'd2;
  localparam logic [1:0] REG_ANG_TOL      = 2'd3;

  localparam logic [12:0] LIN_SPEED_RST    = 13'd2048;
  localparam logic [12:0] ROTATE_SPEED_RST = 13'd1434;
  localparam logic [11:0] POS_TOL_RST      = 12'd123;
  localparam logic [11:0] ANG_TOL_RST      = 12'd246;

  localparam logic signed [16:0] Q_PI       = 17'sd12868;
  localparam logic signed [16:0] Q_THREE_PI = 17'sd38604;
  localparam logic signed [16:0] Q_FIVE_PI  = 17'sd64340;
  localparam logic signed [17:0] Q_TWO_PI   = 18'sd25736;
  localparam logic signed [17:0] Q_FOUR_PI  = 18'sd51472;
  localparam logic signed [17:0] Q_SIX_PI   = 18'sd77208;
  localparam logic [14:0] VEL_LIMIT         = 15'd4096;

  typedef struct packed {
    logic [12:0] lin_speed;
    logic [12:0] rotate_speed;
    logic [11:0] pos_tol;
    logic [11:0] ang_tol;
  } osq_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic                begun;
    logic signed [15:0]  org_x;
    logic signed [15:0]  org_y;
    logic signed [15:0]  org_h;
    logic [1:0]          drop;
    logic                await_ack;
  } osq_state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [13:0] vel_x;
    logic signed [13:0] vel_y;
    logic signed [13:0] turn_rate;
    logic               hold;
    logic [1:0]         pending_drop;
    logic               done;
  } osq_result_t;

  typedef struct packed {
    logic               rotate;
    logic signed [13:0] dir_x;
    logic signed [13:0] dir_y;
    logic signed [13:0] turn;
    logic [13:0]        length;
    logic [1:0]         drop;
  } osq_seg_t;

  function automatic osq_seg_t seg_rom(input logic [IDX_W-1:0] idx);
    osq_seg_t s;
    s = '0;
    case (idx)
      4'd0: begin s.dir_y = 14'sd4096; s.length = 14'd2458; end
      4'd1: begin s.rotate = 1'b1; s.turn = 14'sd4096; s.length = 14'd6434; end
      4'd2: begin s.dir_y = 14'sd4096; s.length = 14'd5530; s.drop = 2'd1; end
      4'd3: begin s.dir_y = -14'sd4096; s.length = 14'd1024; end
      4'd4: begin s.dir_x = 14'sd4096; s.length = 14'd6963; s.drop = 2'd2; end
      4'd5: begin s.dir_x = -14'sd4096; s.length = 14'd819; end
      4'd6: begin s.rotate = 1'b1; s.turn = -14'sd4096; s.length = 14'd12868; end
      4'd7: begin s.dir_y = 14'sd4096; s.length = 14'd3686; end
      4'd8: begin
        s.dir_x = -14'sd2896; s.dir_y = 14'sd2896; s.length = 14'd5816; s.drop = 2'd3;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  // dir * speed / 4096, rounded half away from zero, saturated to +-4096
  function automatic logic signed [13:0] scale_vel(input logic signed [13:0] dir,
                                                   input logic [12:0] speed);
    logic [13:0] mag;
    logic [26:0] prod;
    logic [14:0] r;
    mag  = dir[13] ? 14'(-dir) : 14'(dir);
    prod = 27'(mag) * 27'(speed);
    r    = 15'((prod + 27'd2048) >> 12);
    if (r > VEL_LIMIT) r = VEL_LIMIT;
    return dir[13] ? 14'(-r) : 14'(r);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/osq_cfg_regs.sv =====
// Configuration registers of the odometry segment sequencer.
// Depends on osq_pkg for the register indexes and reset values.
`default_nettype none

module osq_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [12:0]     cfg_wdata,
  output osq_pkg::osq_cfg_t    cfg
);
  import osq_pkg::*;

  osq_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lin_speed    <= LIN_SPEED_RST;
      cfg_r.rotate_speed <= ROTATE_SPEED_RST;
      cfg_r.pos_tol      <= POS_TOL_RST;
      cfg_r.ang_tol      <= ANG_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIN_SPEED:    cfg_r.lin_speed    <= cfg_wdata;
        REG_ROTATE_SPEED: cfg_r.rotate_speed <= cfg_wdata;
        REG_POS_TOL:      cfg_r.pos_tol      <= cfg_wdata[11:0];
        REG_ANG_TOL:      cfg_r.ang_tol      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/osq_seg_eval.sv =====
// Per-request step logic: arrival tests, velocity scaling and next sequencer state.
// Depends on osq_pkg for types, codes and the segment table.
`default_nettype none

module osq_seg_eval #(
  parameter int SEGMENT_COUNT = 9
) (
  input  wire logic [1:0]         action,
  input  wire logic signed [15:0] pose_x,
  input  wire logic signed [15:0] pose_y,
  input  wire logic signed [15:0] pose_theta,
  input  osq_pkg::osq_cfg_t       cfg,
  input  osq_pkg::osq_state_t     st,
  output osq_pkg::osq_state_t     st_nxt,
  output osq_pkg::osq_result_t    res
);
  import osq_pkg::*;

  localparam logic [IDX_W-1:0] SEG_CNT = IDX_W'(SEGMENT_COUNT);

  osq_seg_t           seg;
  logic signed [15:0] ox, oy, oh;
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;
  logic [32:0]        dist_sq;
  logic signed [14:0] t_pos, t_ang;
  logic [27:0]        t_sq;
  logic               move_fin;
  logic signed [16:0] d0;
  logic signed [17:0] wrap_ofs, dwrap, dabs;
  logic               rot_fin;
  logic [IDX_W-1:0]   idx_adv;

  always_comb begin
    seg = seg_rom(st.idx);
    ox  = st.begun ? st.org_x : pose_x;
    oy  = st.begun ? st.org_y : pose_y;
    oh  = st.begun ? st.org_h : pose_theta;

    dx  = 17'(pose_x) - 17'(ox);
    dy  = 17'(pose_y) - 17'(oy);
    adx = dx[16] ? 16'(-dx) : 16'(dx);
    ady = dy[16] ? 16'(-dy) : 16'(dy);
    dist_sq = 33'(32'(adx) * 32'(adx)) + 33'(32'(ady) * 32'(ady));
    t_pos = $signed({1'b0, seg.length}) - $signed({3'b000, cfg.pos_tol});
    t_sq  = 28'(t_pos[13:0]) * 28'(t_pos[13:0]);
    move_fin = (t_pos <= 15'sd0) || (dist_sq >= 33'(t_sq));

    // bring the heading change into [-pi, pi] with one add
    d0 = 17'(pose_theta) - 17'(oh);
    if (d0 > Q_FIVE_PI)        wrap_ofs = -Q_SIX_PI;
    else if (d0 > Q_THREE_PI)  wrap_ofs = -Q_FOUR_PI;
    else if (d0 > Q_PI)        wrap_ofs = -Q_TWO_PI;
    else if (d0 < -Q_FIVE_PI)  wrap_ofs = Q_SIX_PI;
    else if (d0 < -Q_THREE_PI) wrap_ofs = Q_FOUR_PI;
    else if (d0 < -Q_PI)       wrap_ofs = Q_TWO_PI;
    else                       wrap_ofs = '0;
    dwrap = 18'(d0) + wrap_ofs;
    dabs  = dwrap[17] ? -dwrap : dwrap;
    t_ang = $signed({1'b0, seg.length}) - $signed({3'b000, cfg.ang_tol});
    rot_fin = dabs >= 18'(t_ang);

    idx_adv = (st.idx < SEG_CNT) ? IDX_W'(st.idx + 1'b1) : st.idx;
  end

  always_comb begin
    st_nxt        = st;
    res           = '0;
    res.cmd       = CMD_NONE;
    unique case (action)
      ACT_START: begin
        st_nxt.idx       = '0;
        st_nxt.begun     = 1'b0;
        st_nxt.drop      = 2'd0;
        st_nxt.await_ack = 1'b0;
        res.cmd          = CMD_HALT;
      end
      ACT_ACK: begin
        st_nxt.drop      = 2'd0;
        st_nxt.await_ack = 1'b0;
        st_nxt.idx       = idx_adv;
        st_nxt.begun     = 1'b0;
      end
      ACT_UPDATE: begin
        if (!st.await_ack) begin
          if (st.idx >= SEG_CNT) begin
            res.cmd = CMD_HALT;
          end else begin
            st_nxt.org_x = ox;
            st_nxt.org_y = oy;
            st_nxt.org_h = oh;
            st_nxt.begun = 1'b1;
            if (!seg.rotate) begin
              if (move_fin) begin
                res.cmd = CMD_HALT;
                if (seg.drop != 2'd0) begin
                  st_nxt.drop      = seg.drop;
                  st_nxt.await_ack = 1'b1;
                end else begin
                  st_nxt.idx   = idx_adv;
                  st_nxt.begun = 1'b0;
                end
              end else begin
                res.cmd   = CMD_DRIVE;
                res.vel_x = scale_vel(seg.dir_x, cfg.lin_speed);
                res.vel_y = scale_vel(seg.dir_y, cfg.lin_speed);
              end
            end else begin
              if (rot_fin) begin
                res.cmd      = CMD_HALT;
                st_nxt.idx   = idx_adv;
                st_nxt.begun = 1'b0;
              end else begin
                res.cmd       = CMD_DRIVE;
                res.turn_rate = scale_vel(seg.turn, cfg.rotate_speed);
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.hold         = st_nxt.await_ack;
    res.pending_drop = st_nxt.drop;
    res.done         = st_nxt.idx >= SEG_CNT;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/odometry_segment_sequencer.sv =====
// Odometry segment sequencer: steps a fixed table of move and rotate segments
// against pose updates and issues stop or drive commands.
// Depends on osq_pkg, osq_cfg_regs and osq_seg_eval.
//
// Usage:
//   in_*  : one request per beat; in_tuser is the action (start, pose update,
//           drop acknowledge), in_tdata carries the pose.
//   out_* : exactly one result per request, in order; out_tuser is the command.
//   cfg_* : register writes, one per cycle; the user must make them only while the block
//           is idle, since the block itself does not enforce it.
// Path: input register, then result register; the step logic sits between them.
// Throughput: one request per cycle unless stalled; the sequencer state is updated
//   as the request leaves the input register, so the next request sees it at once.
// Stall: with a result waiting and out_tready low the result register holds;
//   an empty input register takes one more request; in_tready then falls until drained.
// Reset: rst_n low clears both registers' valid flags and the sequencer state,
//   and loads the default speeds and tolerances.
`default_nettype none

module odometry_segment_sequencer #(
  parameter int SEGMENT_COUNT = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pose_x, pose_y, pose_theta
  input  wire logic [1:0]  in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // vel_x, vel_y, turn_rate, hold, pending_drop,
                                       // done_res, 2 zero bits
  output logic [1:0]       out_tuser,  // command
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);
  import osq_pkg::*;

  osq_cfg_t    cfg;
  osq_state_t  st_r, st_nxt;
  osq_result_t res, res_r;

  logic               in_valid_r;
  logic [1:0]         act_r;
  logic signed [15:0] px_r, py_r, pt_r;
  logic               out_valid_r;
  logic               step;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  osq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  osq_seg_eval #(
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_eval (
    .action     (act_r),
    .pose_x     (px_r),
    .pose_y     (py_r),
    .pose_theta (pt_r),
    .cfg        (cfg),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      act_r <= in_tuser;
      px_r  <= in_tdata[15:0];
      py_r  <= in_tdata[31:16];
      pt_r  <= in_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.cmd;
  assign out_tdata  = {2'b00, res_r.done, res_r.pending_drop, res_r.hold,
                       res_r.turn_rate, res_r.vel_y, res_r.vel_x};

endmodule

`default_nettype wire

// ===== verif/odometry_segment_sequencer_test.sv =====
// Self-checking testbench for odometry_segment_sequencer: a directed table, then
// random segment walks under several register settings, checked by a local predictor.
// Depends on osq_pkg and the odometry_segment_sequencer RTL.
module odometry_segment_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import osq_pkg::*;

  localparam int SEG_TOTAL = 9;
  localparam int HALF_TURN = 12868;
  localparam int FULL_TURN = 25736;
  localparam int HOLD_OFF = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [15:0] P_MAX = 16'sh7FFF;
  localparam logic signed [15:0] P_MIN = 16'sh8000;
  localparam logic signed [15:0] TH_MAX = 16'sd25736;
  localparam logic signed [15:0] TH_MIN = -16'sd25736;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [13:0] vel_x;
    logic signed [13:0] vel_y;
    logic signed [13:0] turn_rate;
    logic               hold;
    logic [1:0]         drop;
    logic               done;
  } drive_result_t;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pt;
    logic               typed;
    drive_result_t      want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // pose_x, pose_y, pose_theta
  logic [1:0]  in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // vel_x, vel_y, turn_rate, hold, pending_drop, done_res, pad
  logic [1:0]  out_tuser;  // command
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  odometry_segment_sequencer #(.SEGMENT_COUNT(SEG_TOTAL)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // segment table
  bit   seg_turn  [SEG_TOTAL] = '{0, 1, 0, 0, 0, 0, 1, 0, 0};
  int   seg_dir_x [SEG_TOTAL] = '{0, 0, 0, 0, 4096, -4096, 0, 0, -2896};
  int   seg_dir_y [SEG_TOTAL] = '{4096, 0, 4096, -4096, 0, 0, 0, 4096, 2896};
  int   seg_sense [SEG_TOTAL] = '{0, 1, 0, 0, 0, 0, -1, 0, 0};
  int   seg_len   [SEG_TOTAL] = '{2458, 6434, 5530, 1024, 6963, 819, 12868, 3686, 5816};
  int   seg_drop  [SEG_TOTAL] = '{0, 0, 1, 0, 2, 0, 0, 0, 3};

  // predictor copy of registers and sequencer state
  int         move_gain = 2048;
  int         turn_gain = 1434;
  int         reach_slack = 123;
  int         heading_slack = 246;
  int         seg_idx = 0;
  bit         seg_begun = 0;
  int         org_x = 0, org_y = 0, org_h = 0;
  logic [1:0] drop_code = 2'd0;
  bit         await_ack = 0;

  drive_result_t queued_commands[$];
  int error_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int settings_used = 1;
  int runs_finished = 0;
  int cycle_count = 0;
  bit steady = 0;
  bit stall_request = 0;

  script_row_t script [27] = '{
    '{ACT_START,  16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_DRIVE, 14'sd0, 14'sd2048, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd0, 16'sd2335, 16'sd0, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd100, 1'b1,
      '{CMD_DRIVE, 14'sd0, 14'sd0, 14'sd1434, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd6288, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, P_MIN, P_MIN, TH_MIN, 1'b1,
      '{CMD_DRIVE, 14'sd0, 14'sd2048, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, P_MIN, P_MAX, TH_MAX, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b1, 2'd1, 1'b0}},
    '{ACT_UPDATE, 16'sd1, 16'sd1, 16'sd1, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b1, 2'd1, 1'b0}},
    '{ACT_UNUSED, -16'sd1, -16'sd1, -16'sd1, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b1, 2'd1, 1'b0}},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, P_MAX, 16'sd0, 16'sd0, 1'b1,
      '{CMD_DRIVE, 14'sd2048, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, P_MIN, 16'sd0, 16'sd0, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b1, 2'd2, 1'b0}},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd100, 16'sd100, 16'sd0, 1'b1,
      '{CMD_DRIVE, -14'sd2048, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}},
    // one short of the move threshold, then exactly on it
    '{ACT_UPDATE, -16'sd595, 16'sd100, 16'sd0, 1'b0, '0},
    '{ACT_UPDATE, -16'sd596, 16'sd100, 16'sd0, 1'b0, '0},
    '{ACT_UPDATE, 16'sd0, 16'sd0, TH_MAX, 1'b1,
      '{CMD_DRIVE, 14'sd0, 14'sd0, -14'sd1434, 1'b0, 2'd0, 1'b0}},
    // heading difference that only fits after wrapping
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd12868, 1'b0, '0},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{ACT_UPDATE, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_DRIVE, -14'sd1448, 14'sd1448, 14'sd0, 1'b0, 2'd0, 1'b0}},
    '{ACT_UPDATE, 16'sd20000, -16'sd20000, 16'sd0, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b1, 2'd3, 1'b0}},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b1}},
    '{ACT_UPDATE, 16'sd5, 16'sd5, 16'sd5, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b1}},
    '{ACT_ACK, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_NONE, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b1}},
    '{ACT_START, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{CMD_HALT, 14'sd0, 14'sd0, 14'sd0, 1'b0, 2'd0, 1'b0}}
  };

  function automatic int scaled_rate(input int dir, input int speed);
    longint p, m, r;
    p = longint'(dir) * longint'(speed);
    m = (p < 0) ? -p : p;
    r = (m + 2048) / 4096;
    if (r > 4096) r = 4096;
    return int'((p < 0) ? -r : r);
  endfunction

  function automatic void next_segment();
    if (seg_idx < SEG_TOTAL) begin
      seg_idx++;
      if (seg_idx == SEG_TOTAL) runs_finished++;
    end
    seg_begun = 0;
  endfunction

  function automatic drive_result_t sequence_step(input logic [1:0] act,
      input logic signed [15:0] px, input logic signed [15:0] py,
      input logic signed [15:0] pt);
    drive_result_t r;
    longint dx, dy, reach;
    int turn, need;
    r = '0;
    r.cmd = CMD_NONE;
    case (act)
      ACT_START: begin
        seg_idx = 0;
        seg_begun = 0;
        drop_code = 2'd0;
        await_ack = 0;
        r.cmd = CMD_HALT;
      end
      ACT_ACK: begin
        drop_code = 2'd0;
        await_ack = 0;
        next_segment();
      end
      ACT_UPDATE: if (!await_ack) begin
        if (seg_idx >= SEG_TOTAL) begin
          r.cmd = CMD_HALT;
        end else begin
          if (!seg_begun) begin
            org_x = px;
            org_y = py;
            org_h = pt;
            seg_begun = 1;
          end
          if (!seg_turn[seg_idx]) begin
            dx = longint'(px) - org_x;
            dy = longint'(py) - org_y;
            reach = seg_len[seg_idx] - reach_slack;
            if (reach <= 0 || dx * dx + dy * dy >= reach * reach) begin
              r.cmd = CMD_HALT;
              if (seg_drop[seg_idx] != 0) begin
                drop_code = 2'(seg_drop[seg_idx]);
                await_ack = 1;
              end else begin
                next_segment();
              end
            end else begin
              r.cmd = CMD_DRIVE;
              r.vel_x = 14'(scaled_rate(seg_dir_x[seg_idx], move_gain));
              r.vel_y = 14'(scaled_rate(seg_dir_y[seg_idx], move_gain));
            end
          end else begin
            turn = int'(pt) - org_h;
            while (turn > HALF_TURN) turn -= FULL_TURN;
            while (turn < -HALF_TURN) turn += FULL_TURN;
            if (turn < 0) turn = -turn;
            need = seg_len[seg_idx] - heading_slack;
            if (turn >= need) begin
              r.cmd = CMD_HALT;
              next_segment();
            end else begin
              r.cmd = CMD_DRIVE;
              r.turn_rate = 14'(scaled_rate(seg_sense[seg_idx] * 4096, turn_gain));
            end
          end
        end
      end
      default: ;
    endcase
    r.hold = await_ack;
    r.drop = drop_code;
    r.done = (seg_idx >= SEG_TOTAL);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] result %0d %s: got %0d, expected %0d", $realtime, results_seen, what,
             got, want);
  endtask

  task automatic push_request(input logic [1:0] act, input logic signed [15:0] px,
      input logic signed [15:0] py, input logic signed [15:0] pt,
      input logic typed, input drive_result_t want);
    drive_result_t r;
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {pt, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = sequence_step(act, px, py, pt);
    queued_commands.push_back(typed ? want : r);
    requests_sent++;
  endtask

  // mostly legal walks through the segment table, with some noise mixed in
  task automatic random_requests(input int count);
    logic [1:0] act;
    logic signed [15:0] px, py, pt;
    int roll, need, span;
    repeat (count) begin
      roll = $urandom_range(99);
      px = 16'($urandom);
      py = 16'($urandom);
      pt = 16'(int'($urandom_range(2 * FULL_TURN)) - FULL_TURN);
      if (roll < 12) begin
        act = 2'($urandom_range(3));
      end else if (await_ack) begin
        act = (roll < 90) ? ACT_ACK : ACT_UPDATE;
      end else if (seg_idx >= SEG_TOTAL) begin
        act = (roll < 70) ? ACT_START : ACT_UPDATE;
      end else if (roll < 15) begin
        act = ACT_START;
      end else begin
        act = ACT_UPDATE;
        if (seg_begun) begin
          need = seg_len[seg_idx] - (seg_turn[seg_idx] ? heading_slack : reach_slack);
          if (need < 0) need = 0;
          span = (roll < 55) ? int'($urandom_range(need))
                             : need + int'($urandom_range(200)) - 100;
          if (span < 0) span = 0;
          if ($urandom_range(1)) span = -span;
          if (seg_turn[seg_idx]) begin
            if (span > HALF_TURN) span = HALF_TURN;
            if (span < -HALF_TURN) span = -HALF_TURN;
            span += org_h;
            if (span > FULL_TURN) span -= FULL_TURN;
            if (span < -FULL_TURN) span += FULL_TURN;
            pt = 16'(span);
          end else if ($urandom_range(1)) begin
            px = 16'(org_x + span);
            py = 16'(org_y + int'($urandom_range(64)) - 32);
          end else begin
            py = 16'(org_y + span);
            px = 16'(org_x + int'($urandom_range(64)) - 32);
          end
        end
      end
      push_request(act, px, py, pt, 1'b0, '0);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LIN_SPEED:    move_gain = int'(val);
      REG_ROTATE_SPEED: turn_gain = int'(val);
      REG_POS_TOL:      reach_slack = int'(val[11:0]);
      REG_ANG_TOL:      heading_slack = int'(val[11:0]);
      default: ;
    endcase
  endtask

  task automatic settle_and_configure(input int ms, input int rs, input int ptol,
      input int atol);
    in_tvalid <= 1'b0;
    while (queued_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(REG_LIN_SPEED, 13'(ms));
    write_register(REG_ROTATE_SPEED, 13'(rs));
    write_register(REG_POS_TOL, 13'(ptol));
    write_register(REG_ANG_TOL, 13'(atol));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    drive_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cmd = out_tuser;
      got.vel_x = out_tdata[13:0];
      got.vel_y = out_tdata[27:14];
      got.turn_rate = out_tdata[41:28];
      got.hold = out_tdata[42];
      got.drop = out_tdata[44:43];
      got.done = out_tdata[45];
      results_seen++;
      if (queued_commands.size() == 0) begin
        report_mismatch("unexpected, command", int'(got.cmd), -1);
      end else begin
        want = queued_commands.pop_front();
        if (got.cmd != want.cmd) report_mismatch("command", got.cmd, want.cmd);
        if (got.vel_x != want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
        if (got.vel_y != want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
        if (got.turn_rate != want.turn_rate)
          report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
        if (got.hold != want.hold) report_mismatch("hold", got.hold, want.hold);
        if (got.drop != want.drop) report_mismatch("pending_drop", got.drop, want.drop);
        if (got.done != want.done) report_mismatch("done_res", got.done, want.done);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               queued_commands.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink: random backpressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 36);
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_START;
    cfg_we = 1'b0;
    cfg_index = REG_LIN_SPEED;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      push_request(script[i].act, script[i].px, script[i].py, script[i].pt,
                   script[i].typed, script[i].want);

    settle_and_configure(4096, 4096, 0, 0);
    random_requests(110);
    settle_and_configure(0, 0, 4095, 4095);
    random_requests(90);
    settle_and_configure(8191, 5000, 600, 1200);
    steady = 1;
    stall_request = 1;
    random_requests(120);
    steady = 0;
    repeat (3) begin
      settle_and_configure(int'($urandom_range(4096)), int'($urandom_range(8191)),
                           int'($urandom_range(8191)), int'($urandom_range(8191)));
      random_requests(110);
    end

    in_tvalid <= 1'b0;
    while (queued_commands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d requests and %0d results under %0d register settings;",
             requests_sent, results_seen, settings_used);
    $display("the full segment table was completed %0d times.", runs_finished);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/osq_pkg.sv
hw/rtl/osq_cfg_regs.sv
hw/rtl/osq_seg_eval.sv
hw/rtl/odometry_segment_sequencer.sv
verif/odometry_segment_sequencer_test.sv
